[rtl/core/grs_pkg.sv]
// ---------------------------------------------------------------------------
// grs_pkg: shared types and constants for the reaction step core
// Micro-op codes, command/status structs, rate and stoichiometry tables,
// and the log table builder.
// ---------------------------------------------------------------------------
package grs_pkg;

  localparam int NUM_SPECIES   = 7;
  localparam int NUM_REACTIONS = 15;

  // input word op codes
  localparam logic OP_START_RUN = 1'b0;
  localparam logic OP_STEP      = 1'b1;

  // config register indexes
  localparam logic [2:0] CFG_STOP_TIME = 3'd0;

  localparam logic [3:0] RXN_NONE = 4'd15;
  localparam logic [3:0] RXN_LAST = 4'd14;
  localparam logic [2:0] SP_NONE  = 3'd7;  // no species / unit factor

  localparam logic [31:0] STOP_RESET = 32'd6553600;
  localparam logic [15:0] LN2_Q16    = 16'd45426;

  localparam logic [15:0] INIT_RESET [NUM_SPECIES] =
    '{16'd900, 16'd900, 16'd30, 16'd330, 16'd50, 16'd270, 16'd20};

  // linear propensities: coef * count (or coef alone for SP_NONE)
  localparam logic [20:0] LIN_COEF [NUM_REACTIONS] =
    '{21'd1310720, 21'd983, 21'd0, 21'd32768, 21'd1311, 21'd0, 21'd983,
      21'd39322, 21'd1311, 21'd39322, 21'd4260, 21'd3277, 21'd11141,
      21'd1311, 21'd983};
  localparam logic [2:0] LIN_SP [NUM_REACTIONS] =
    '{3'd7, 3'd0, 3'd7, 3'd7, 3'd1, 3'd7, 3'd2, 3'd2, 3'd3, 3'd3,
      3'd4, 3'd4, 3'd5, 3'd6, 3'd6};
  localparam logic [NUM_REACTIONS-1:0] IS_BITE = 15'b000_0000_0010_0100;

  // saturating bite terms
  localparam logic [11:0] BITE_K       [2] = '{12'd1475, 12'd2458};
  localparam logic [15:0] BITE_NU      [2] = '{16'd32768, 16'd9830};
  localparam logic [2:0]  BITE_C_SP    [2] = '{3'd5, 3'd4};
  localparam logic [2:0]  BITE_HOST_SP [2] = '{3'd0, 3'd1};
  localparam logic [3:0]  BITE_RXN     [2] = '{4'd2, 4'd5};

  localparam logic [2:0] LOSE_SP [NUM_REACTIONS] =
    '{3'd7, 3'd0, 3'd0, 3'd7, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3,
      3'd4, 3'd4, 3'd5, 3'd6, 3'd6};
  localparam logic [2:0] GAIN_SP [NUM_REACTIONS] =
    '{3'd0, 3'd7, 3'd2, 3'd1, 3'd7, 3'd3, 3'd7, 3'd4, 3'd7, 3'd5,
      3'd7, 3'd6, 3'd7, 3'd0, 3'd7};

  // datapath micro-ops
  localparam logic [4:0] UOP_NOP      = 5'd0;
  localparam logic [4:0] UOP_START    = 5'd1;
  localparam logic [4:0] UOP_SKIP     = 5'd2;
  localparam logic [4:0] UOP_LOAD     = 5'd3;
  localparam logic [4:0] UOP_NU       = 5'd4;
  localparam logic [4:0] UOP_DIV_FRAC = 5'd5;
  localparam logic [4:0] UOP_KF       = 5'd6;
  localparam logic [4:0] UOP_KFH      = 5'd7;
  localparam logic [4:0] UOP_WBITE    = 5'd8;
  localparam logic [4:0] UOP_LIN      = 5'd9;
  localparam logic [4:0] UOP_NORM     = 5'd10;
  localparam logic [4:0] UOP_BASE     = 5'd11;
  localparam logic [4:0] UOP_NEGLOG   = 5'd12;
  localparam logic [4:0] UOP_DIV_TAU  = 5'd13;
  localparam logic [4:0] UOP_TLO      = 5'd14;
  localparam logic [4:0] UOP_THI      = 5'd15;
  localparam logic [4:0] UOP_TGT      = 5'd16;
  localparam logic [4:0] UOP_SEARCH   = 5'd17;
  localparam logic [4:0] UOP_APPLY    = 5'd18;
  localparam logic [4:0] UOP_EMIT     = 5'd19;

  typedef struct packed {
    logic [4:0] uop;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic div_done;
    logic hit;
    logic out_free;
  } stat_t;

  // shift-subtract quotient for table building; elaboration only
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned d);
    longint unsigned q, rm;
    q  = 0;
    rm = 0;
    for (int i = 63; i >= 0; i--) begin
      rm = (rm << 1) | ((a >> i) & 64'd1);
      if (rm >= d) begin
        rm = rm - d;
        q  = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // ln(1 + k/2^b) in Q.16 via 2*atanh series in Q2.30; elaboration only
  function automatic logic [15:0] ln_entry(input int unsigned k, input int unsigned b);
    longint unsigned z, z2, pw, acc, n, den, r;
    den = (64'd1 << (b + 1)) + 64'(k);
    z   = udiv64(64'(k) << 30, den);
    z2  = (z * z) >> 30;
    pw  = z;
    acc = 0;
    n   = 1;
    for (int i = 0; i < 100; i++) begin
      if (pw != 0) begin
        acc = acc + udiv64(pw, n);
        pw  = (pw * z2) >> 30;
        n   = n + 2;
      end
    end
    r = ((2 * acc) + (64'd1 << 13)) >> 14;
    return r[15:0];
  endfunction

endpackage

[rtl/core/grs_div.sv]
// ---------------------------------------------------------------------------
// grs_div: shared restoring divider
// One quotient bit per cycle; quotient known to fit in QW bits.
// ---------------------------------------------------------------------------
module grs_div #(
  parameter int DVW = 48,
  parameter int DSW = 37,
  parameter int QW  = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic [QW-1:0]  quo,
  output logic           done
);

  localparam int CW = $clog2(QW + 1);

  logic [DSW-1:0] rem_r, rem_nxt, dsr_r;
  logic [QW-1:0]  dvd_r, quo_r, quo_nxt;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r;
  logic [DSW:0]   trial;

  always_comb begin
    trial = {rem_r, dvd_r[QW-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = DSW'(trial - {1'b0, dsr_r});
      quo_nxt = {quo_r[QW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DSW-1:0];
      quo_nxt = {quo_r[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(QW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DSW'(dividend >> QW);
      dvd_r <= dividend[QW-1:0];
      dsr_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[QW-2:0], 1'b0};
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

[rtl/core/grs_dp.sv]
// ---------------------------------------------------------------------------
// grs_dp: reaction step datapath
// State, config registers, shared multiplier, divider, log table and
// output register, driven one micro-op per cycle.
// ---------------------------------------------------------------------------
module grs_dp #(
  parameter int COUNT_BITS     = 16,
  parameter int LOG_TABLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  grs_pkg::cmd_t       cmd,
  output grs_pkg::stat_t      stat,
  input  logic [31:0]         in_draw_wait,
  input  logic [31:0]         in_draw_pick,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [3:0]          out_reaction_fired,
  output logic [31:0]         out_elapsed_time,
  output logic [15:0]         out_count [grs_pkg::NUM_SPECIES],
  output logic                out_run_done,
  output logic                out_saturated
);

  localparam int CB   = COUNT_BITS;
  localparam int WW   = CB + 17;
  localparam int SUMW = CB + 21;
  localparam int MAW  = (SUMW > 32) ? SUMW : 32;
  localparam int MBW  = (CB > 16) ? CB : 16;
  localparam int PW   = MAW + MBW;
  localparam int DVW  = 32 + CB;
  localparam int QW   = 20;
  localparam int ROMN = 1 << LOG_TABLE_BITS;
  localparam int NS   = grs_pkg::NUM_SPECIES;
  localparam int NR   = grs_pkg::NUM_REACTIONS;
  localparam logic [CB-1:0] CNT_MAX = '1;

  logic [31:0]   stop_r;
  logic [15:0]   init_r [NS];
  logic [CB-1:0] cnt_r [NS];
  logic [31:0]   clock_r;
  logic          fin_r;
  logic [31:0]   x_r;
  logic [4:0]    lz_r;
  logic [31:0]   dp_r;
  logic [PW-1:0] p_r;
  logic [WW-1:0] w_r [NR];
  logic [SUMW-1:0] sum_r, acc_r, tgt_r, cum_r, cum_nxt;
  logic          pend_r;
  logic [3:0]    pidx_r;
  logic [15:0]   rom_q;
  logic [20:0]   neglog_r;
  logic [3:0]    fired_r;
  logic          sat_r;
  logic          out_valid_r;

  logic          sel;
  logic [2:0]    rd_sp;
  logic [CB-1:0] cnt_rd;
  logic [MAW-1:0] mul_a;
  logic [MBW-1:0] mul_b;
  logic          mul_en;
  logic [DVW-1:0] div_dvd;
  logic [SUMW-1:0] div_dsr;
  logic          div_start;
  logic [QW-1:0] quo;
  logic          div_done;
  logic [WW-1:0] w_sel;
  logic          hit;
  logic [15:0]   rom_w [ROMN];

  genvar gk;
  generate
    for (gk = 0; gk < ROMN; gk++) begin : g_rom
      assign rom_w[gk] = grs_pkg::ln_entry(gk, LOG_TABLE_BITS);
    end
  endgenerate

  assign sel = cmd.idx[0];

  // single count read port
  always_comb begin
    case (cmd.uop)
      grs_pkg::UOP_NU, grs_pkg::UOP_DIV_FRAC: rd_sp = grs_pkg::BITE_C_SP[sel];
      grs_pkg::UOP_KFH: rd_sp = grs_pkg::BITE_HOST_SP[sel];
      grs_pkg::UOP_LIN: rd_sp = (cmd.idx == grs_pkg::RXN_NONE) ? grs_pkg::SP_NONE
                                                                 : grs_pkg::LIN_SP[cmd.idx];
      default: rd_sp = grs_pkg::SP_NONE;
    endcase
    cnt_rd = CB'(1);
    for (int i = 0; i < NS; i++) begin
      if (rd_sp == 3'(i)) cnt_rd = cnt_r[i];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.uop)
      grs_pkg::UOP_NU: begin
        mul_a = MAW'(grs_pkg::BITE_NU[sel]);
        mul_b = MBW'(cnt_rd);
      end
      grs_pkg::UOP_KF: begin
        mul_a = MAW'(quo);
        mul_b = MBW'(grs_pkg::BITE_K[sel]);
      end
      grs_pkg::UOP_KFH: begin
        mul_a = p_r[MAW-1:0];
        mul_b = MBW'(cnt_rd);
      end
      grs_pkg::UOP_LIN: begin
        mul_a = (cmd.idx == grs_pkg::RXN_NONE) ? '0 : MAW'(grs_pkg::LIN_COEF[cmd.idx]);
        mul_b = MBW'(cnt_rd);
        mul_en = (cmd.idx != grs_pkg::RXN_NONE);
      end
      grs_pkg::UOP_BASE: begin
        mul_a = MAW'(grs_pkg::LN2_Q16);
        mul_b = MBW'({1'b0, lz_r} + 6'd1);
      end
      grs_pkg::UOP_TLO: begin
        mul_a = MAW'(sum_r);
        mul_b = MBW'(dp_r[15:0]);
      end
      grs_pkg::UOP_THI: begin
        mul_a = MAW'(sum_r);
        mul_b = MBW'(dp_r[31:16]);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd.uop == grs_pkg::UOP_DIV_FRAC) begin
      div_dvd = {cnt_rd, 32'd0};
      div_dsr = SUMW'(p_r) + SUMW'(65536);
    end else begin
      div_dvd = DVW'(neglog_r) << 16;
      div_dsr = sum_r;
    end
  end
  assign div_start = (cmd.uop == grs_pkg::UOP_DIV_FRAC) || (cmd.uop == grs_pkg::UOP_DIV_TAU);

  grs_div #(.DVW(DVW), .DSW(SUMW), .QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quo      (quo),
    .done     (div_done)
  );

  // cumulative search
  assign w_sel   = (cmd.idx == grs_pkg::RXN_NONE) ? '0 : w_r[cmd.idx];
  assign cum_nxt = cum_r + SUMW'(w_sel);
  assign hit     = (cum_nxt >= tgt_r) || (cmd.idx == grs_pkg::RXN_LAST);

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= grs_pkg::STOP_RESET;
      for (int i = 0; i < NS; i++) init_r[i] <= grs_pkg::INIT_RESET[i];
    end else if (cfg_we) begin
      if (cfg_index == grs_pkg::CFG_STOP_TIME) stop_r <= cfg_wdata;
      for (int i = 0; i < NS; i++) begin
        if (cfg_index == 3'(i + 1)) init_r[i] <= cfg_wdata[15:0];
      end
    end
  end

  // run state
  logic [32:0] nclk;
  logic [2:0]  lose, gain;
  assign nclk = {1'b0, clock_r} + 33'(quo);
  assign lose = grs_pkg::LOSE_SP[fired_r];
  assign gain = grs_pkg::GAIN_SP[fired_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        cnt_r[i] <= (32'(grs_pkg::INIT_RESET[i]) > 32'(CNT_MAX)) ? CNT_MAX
                                                               : CB'(grs_pkg::INIT_RESET[i]);
      end
      clock_r <= '0;
      fin_r   <= 1'b0;
      fired_r <= grs_pkg::RXN_NONE;
      sat_r   <= 1'b0;
    end else begin
      case (cmd.uop)
        grs_pkg::UOP_START: begin
          sat_r <= 1'b0;
          for (int i = 0; i < NS; i++) begin
            if (32'(init_r[i]) > 32'(CNT_MAX)) begin
              cnt_r[i] <= CNT_MAX;
              sat_r    <= 1'b1;
            end else begin
              cnt_r[i] <= CB'(init_r[i]);
            end
          end
          clock_r <= '0;
          fin_r   <= (stop_r == 32'd0);
          fired_r <= grs_pkg::RXN_NONE;
        end
        grs_pkg::UOP_SKIP: begin
          fin_r   <= 1'b1;
          fired_r <= grs_pkg::RXN_NONE;
          sat_r   <= 1'b0;
        end
        grs_pkg::UOP_LOAD: sat_r <= 1'b0;
        grs_pkg::UOP_SEARCH: if (hit) fired_r <= cmd.idx;
        grs_pkg::UOP_APPLY: begin
          for (int i = 0; i < NS; i++) begin
            if (lose == 3'(i)) begin
              if (cnt_r[i] == '0) sat_r <= 1'b1;
              else cnt_r[i] <= cnt_r[i] - 1'b1;
            end
            if (gain == 3'(i)) begin
              if (cnt_r[i] == CNT_MAX) sat_r <= 1'b1;
              else cnt_r[i] <= cnt_r[i] + 1'b1;
            end
          end
          if (nclk[32]) begin
            clock_r <= '1;
            sat_r   <= 1'b1;
            fin_r   <= 1'b1;
          end else begin
            clock_r <= nclk[31:0];
            fin_r   <= (nclk[31:0] >= stop_r);
          end
        end
        default: ;
      endcase
    end
  end

  // propensity / time / target datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      if (mul_en) p_r <= PW'(mul_a * mul_b);
      case (cmd.uop)
        grs_pkg::UOP_LOAD: begin
          sum_r  <= '0;
          pend_r <= 1'b0;
          x_r    <= (in_draw_wait == 32'd0) ? 32'd1 : in_draw_wait;
          lz_r   <= '0;
          dp_r   <= in_draw_pick;
        end
        grs_pkg::UOP_WBITE: begin
          w_r[grs_pkg::BITE_RXN[sel]] <= WW'(p_r >> 16);
          sum_r <= sum_r + SUMW'(p_r >> 16);
        end
        grs_pkg::UOP_LIN: begin
          if (pend_r) begin
            w_r[pidx_r] <= p_r[WW-1:0];
            sum_r <= sum_r + SUMW'(p_r[WW-1:0]);
          end
          pidx_r <= cmd.idx;
          pend_r <= (cmd.idx != grs_pkg::RXN_NONE) && !grs_pkg::IS_BITE[cmd.idx];
        end
        grs_pkg::UOP_NORM: begin
          case (cmd.idx)
            4'd0: if (x_r[31:16] == '0) begin x_r <= x_r << 16; lz_r <= lz_r + 5'd16; end
            4'd1: if (x_r[31:24] == '0) begin x_r <= x_r << 8;  lz_r <= lz_r + 5'd8;  end
            4'd2: if (x_r[31:28] == '0) begin x_r <= x_r << 4;  lz_r <= lz_r + 5'd4;  end
            4'd3: if (x_r[31:30] == '0) begin x_r <= x_r << 2;  lz_r <= lz_r + 5'd2;  end
            default: if (!x_r[31]) begin x_r <= x_r << 1; lz_r <= lz_r + 5'd1; end
          endcase
        end
        grs_pkg::UOP_BASE: rom_q <= rom_w[x_r[30 -: LOG_TABLE_BITS]];
        grs_pkg::UOP_NEGLOG:
          neglog_r <= (21'(rom_q) > p_r[20:0]) ? '0 : p_r[20:0] - 21'(rom_q);
        grs_pkg::UOP_THI: acc_r <= SUMW'(p_r >> 16);
        grs_pkg::UOP_TGT: begin
          tgt_r <= SUMW'(({1'b0, p_r} + (PW + 1)'(acc_r)) >> 16);
          cum_r <= '0;
        end
        grs_pkg::UOP_SEARCH: cum_r <= cum_nxt;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.uop == grs_pkg::UOP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.uop == grs_pkg::UOP_EMIT) begin
      out_reaction_fired <= fired_r;
      out_elapsed_time   <= clock_r;
      for (int i = 0; i < NS; i++) out_count[i] <= 16'(cnt_r[i]);
      out_run_done  <= fin_r;
      out_saturated <= sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.halted   = fin_r || (clock_r >= stop_r);
  assign stat.div_done = div_done;
  assign stat.hit      = hit;
  assign stat.out_free = !out_valid_r || !out_stall;

  a_start_clears_clock: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.uop == grs_pkg::UOP_START |=> clock_r == 32'd0)
    else $error("clock not cleared by start");

  a_tau_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.uop == grs_pkg::UOP_DIV_TAU |-> sum_r != '0)
    else $error("propensity sum zero at time division");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.uop == grs_pkg::UOP_EMIT |-> (!out_valid_r || !out_stall))
    else $error("result emitted over a held word");

endmodule

[rtl/core/grs_ctrl.sv]
// ---------------------------------------------------------------------------
// grs_ctrl: reaction step sequencer
// Walks start or skip, bite terms, linear terms, log, divisions, search, apply and emit.
// ---------------------------------------------------------------------------
module grs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_op,
  input  grs_pkg::stat_t stat,
  output grs_pkg::cmd_t  cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_NU     = 5'd1;
  localparam logic [4:0] S_DIVF   = 5'd2;
  localparam logic [4:0] S_WAITF  = 5'd3;
  localparam logic [4:0] S_KF     = 5'd4;
  localparam logic [4:0] S_KFH    = 5'd5;
  localparam logic [4:0] S_WBITE  = 5'd6;
  localparam logic [4:0] S_LIN    = 5'd7;
  localparam logic [4:0] S_NORM   = 5'd8;
  localparam logic [4:0] S_BASE   = 5'd9;
  localparam logic [4:0] S_NEGLOG = 5'd10;
  localparam logic [4:0] S_DIVT   = 5'd11;
  localparam logic [4:0] S_TLO    = 5'd12;
  localparam logic [4:0] S_THI    = 5'd13;
  localparam logic [4:0] S_TGT    = 5'd14;
  localparam logic [4:0] S_SEARCH = 5'd15;
  localparam logic [4:0] S_WAITT  = 5'd16;
  localparam logic [4:0] S_APPLY  = 5'd17;
  localparam logic [4:0] S_RESULT = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.uop   = grs_pkg::UOP_NOP;
    cmd.idx   = cnt_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        if (in_op == grs_pkg::OP_START_RUN) begin
          cmd.uop   = grs_pkg::UOP_START;
          state_nxt = S_RESULT;
        end else if (stat.halted) begin
          cmd.uop   = grs_pkg::UOP_SKIP;
          state_nxt = S_RESULT;
        end else begin
          cmd.uop   = grs_pkg::UOP_LOAD;
          cnt_nxt   = '0;
          state_nxt = S_NU;
        end
      end
      S_NU: begin
        cmd.uop   = grs_pkg::UOP_NU;
        state_nxt = S_DIVF;
      end
      S_DIVF: begin
        cmd.uop   = grs_pkg::UOP_DIV_FRAC;
        state_nxt = S_WAITF;
      end
      S_WAITF: if (stat.div_done) state_nxt = S_KF;
      S_KF: begin
        cmd.uop   = grs_pkg::UOP_KF;
        state_nxt = S_KFH;
      end
      S_KFH: begin
        cmd.uop   = grs_pkg::UOP_KFH;
        state_nxt = S_WBITE;
      end
      S_WBITE: begin
        cmd.uop = grs_pkg::UOP_WBITE;
        cnt_nxt = '0;
        state_nxt = (cnt_r == 4'd0) ? S_NU : S_LIN;
        if (cnt_r == 4'd0) cnt_nxt = 4'd1;
      end
      S_LIN: begin
        cmd.uop = grs_pkg::UOP_LIN;
        if (cnt_r == grs_pkg::RXN_NONE) begin
          cnt_nxt   = '0;
          state_nxt = S_NORM;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_NORM: begin
        cmd.uop = grs_pkg::UOP_NORM;
        if (cnt_r == 4'd4) state_nxt = S_BASE;
        else cnt_nxt = cnt_r + 4'd1;
      end
      S_BASE: begin
        cmd.uop   = grs_pkg::UOP_BASE;
        state_nxt = S_NEGLOG;
      end
      S_NEGLOG: begin
        cmd.uop   = grs_pkg::UOP_NEGLOG;
        state_nxt = S_DIVT;
      end
      S_DIVT: begin
        cmd.uop   = grs_pkg::UOP_DIV_TAU;
        state_nxt = S_TLO;
      end
      S_TLO: begin
        cmd.uop   = grs_pkg::UOP_TLO;
        state_nxt = S_THI;
      end
      S_THI: begin
        cmd.uop   = grs_pkg::UOP_THI;
        state_nxt = S_TGT;
      end
      S_TGT: begin
        cmd.uop   = grs_pkg::UOP_TGT;
        cnt_nxt   = '0;
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.uop = grs_pkg::UOP_SEARCH;
        if (stat.hit) state_nxt = S_WAITT;
        else cnt_nxt = cnt_r + 4'd1;
      end
      S_WAITT: if (stat.div_done) state_nxt = S_APPLY;
      S_APPLY: begin
        cmd.uop   = grs_pkg::UOP_APPLY;
        state_nxt = S_RESULT;
      end
      S_RESULT: if (stat.out_free) begin
        cmd.uop   = grs_pkg::UOP_EMIT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[rtl/core/gillespie_reaction_step_core.sv]
// ---------------------------------------------------------------------------
// gillespie_reaction_step_core: direct-method SSA reaction step
// Order: start and after-stop words go straight to the result state; a step word
//   walks two bite terms (each with a 20-bit division), 16 linear-term slots,
//   5 normalize steps, and the wait-time division, which hides the search.
// Flow: one word at a time; a new word is taken only in idle, and the result
//   is emitted only once the output register (which holds a result until taken)
//   is free.
// Reset: synchronous active low; counts and config return to defaults.
// ---------------------------------------------------------------------------
module gillespie_reaction_step_core #(
  parameter int COUNT_BITS     = 16,
  parameter int LOG_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_draw_wait,
  input  logic [31:0] in_draw_pick,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_reaction_fired,
  output logic [31:0] out_elapsed_time,
  output logic [15:0] out_count_s_h,
  output logic [15:0] out_count_s_m,
  output logic [15:0] out_count_e_h,
  output logic [15:0] out_count_e_m,
  output logic [15:0] out_count_i_h,
  output logic [15:0] out_count_i_m,
  output logic [15:0] out_count_r_h,
  output logic        out_run_done,
  output logic        out_saturated,
  // config writes: 0 stop time, 1..7 initial counts
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  grs_pkg::cmd_t  cmd;
  grs_pkg::stat_t stat;
  logic [15:0]    cnt_out [grs_pkg::NUM_SPECIES];

  // sequencer: one micro-op per cycle to the datapath
  grs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: counts, clock, propensities, divider, log table, output reg
  grs_dp #(
    .COUNT_BITS     (COUNT_BITS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_draw_wait       (in_draw_wait),
    .in_draw_pick       (in_draw_pick),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_reaction_fired (out_reaction_fired),
    .out_elapsed_time   (out_elapsed_time),
    .out_count          (cnt_out),
    .out_run_done       (out_run_done),
    .out_saturated      (out_saturated)
  );

  assign out_count_s_h = cnt_out[0];
  assign out_count_s_m = cnt_out[1];
  assign out_count_e_h = cnt_out[2];
  assign out_count_e_m = cnt_out[3];
  assign out_count_i_h = cnt_out[4];
  assign out_count_i_m = cnt_out[5];
  assign out_count_r_h = cnt_out[6];

endmodule

[bench/gillespie_reaction_step_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gillespie_reaction_step_core_tb: self-checking bench for the SSA step core
// Drives start and step words with random draws and idle gaps on both sides.
// A fixed-point behavioral step predicts each result no directed row types in.
// Config changes between phases cover extreme stop times and initial counts.
// ---------------------------------------------------------------------------
module gillespie_reaction_step_core_tb;

  localparam int  CNT_TOP   = 65535;
  localparam int  LOG_BITS  = 10;
  localparam int  DRAIN_CYC = 200;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam int  NUM_RANDOM = 520;

  typedef struct packed {
    logic [3:0]  rxn;
    logic [31:0] clock_q16;
    logic [15:0] sh, sm, eh, em, ih, im, rh;
    logic        done;
    logic        sat;
  } step_result_t;

  typedef struct {
    logic        op;
    logic [31:0] dw;
    logic [31:0] dp;
    logic        known;   // expected result typed in below
    step_result_t want;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_op;
  logic [31:0] in_draw_wait, in_draw_pick;
  logic out_valid, out_stall;
  logic [3:0]  out_reaction_fired;
  logic [31:0] out_elapsed_time;
  logic [15:0] out_count_s_h, out_count_s_m, out_count_e_h, out_count_e_m;
  logic [15:0] out_count_i_h, out_count_i_m, out_count_r_h;
  logic out_run_done, out_saturated;
  logic cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  gillespie_reaction_step_core u_dut (.*);

  // predictor state
  longint unsigned stop_q16;
  longint unsigned init_cnt [grs_pkg::NUM_SPECIES];
  longint unsigned counts   [grs_pkg::NUM_SPECIES];
  longint unsigned clock_q16;
  bit              run_finished;
  longint unsigned ln_table [1 << LOG_BITS];

  step_result_t expected_q [$];
  int  errors;
  int  words_sent, words_checked, steps_fired;
  longint cycles = 0;
  bit  no_idle;   // long stretch without idling

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ln(1+k/2^B) in Q.16 through the 2*atanh series
  function automatic longint unsigned log_rom_entry(longint unsigned k);
    longint unsigned z, z2, pw, acc, n;
    z   = (k << 30) / ((64'd1 << (LOG_BITS + 1)) + k);
    z2  = (z * z) >> 30;
    pw  = z;
    acc = 0;
    n   = 1;
    while (pw != 0 && n < 200) begin
      acc += pw / n;
      pw  = (pw * z2) >> 30;
      n   += 2;
    end
    return ((2 * acc) + (64'd1 << 13)) >> 14;
  endfunction

  function automatic longint unsigned wait_neglog(logic [31:0] dw_in);
    longint unsigned dw, idx, base;
    int e;
    dw = (dw_in == 0) ? 1 : dw_in;
    e = 31;
    while (((dw >> e) & 1) == 0) e--;
    if (e >= LOG_BITS) idx = dw >> (e - LOG_BITS);
    else               idx = dw << (LOG_BITS - e);
    idx &= (1 << LOG_BITS) - 1;
    base = longint'(32 - e) * grs_pkg::LN2_Q16;
    return (ln_table[idx] > base) ? 0 : base - ln_table[idx];
  endfunction

  function automatic longint unsigned bite_rate(longint unsigned k, longint unsigned nu,
                                                longint unsigned host,
                                                longint unsigned carrier);
    longint unsigned frac;
    frac = (carrier << 32) / (65536 + nu * carrier);
    return (k * host * frac) >> 16;
  endfunction

  function automatic step_result_t pack_result(logic [3:0] rxn, bit sat);
    step_result_t r;
    r.rxn = rxn;
    r.clock_q16 = clock_q16[31:0];
    r.sh = 16'(counts[0]); r.sm = 16'(counts[1]); r.eh = 16'(counts[2]);
    r.em = 16'(counts[3]); r.ih = 16'(counts[4]); r.im = 16'(counts[5]);
    r.rh = 16'(counts[6]);
    r.done = run_finished;
    r.sat = sat;
    return r;
  endfunction

  // one word through the behavioral step
  function automatic step_result_t advance_epidemic(logic op, logic [31:0] dw,
                                                    logic [31:0] dp);
    longint unsigned w [grs_pkg::NUM_REACTIONS];
    longint unsigned total, tau, target, cum, nclk;
    int r;
    bit sat;
    logic [3:0] rxn;
    sat = 0;
    rxn = grs_pkg::RXN_NONE;
    if (op == grs_pkg::OP_START_RUN) begin
      foreach (counts[i]) counts[i] = init_cnt[i];
      clock_q16 = 0;
      run_finished = (stop_q16 == 0);
    end else if (run_finished || clock_q16 >= stop_q16) begin
      run_finished = 1;
    end else begin
      for (int i = 0; i < grs_pkg::NUM_REACTIONS; i++) begin
        if (grs_pkg::IS_BITE[i]) w[i] = 0;
        else if (grs_pkg::LIN_SP[i] == grs_pkg::SP_NONE) w[i] = grs_pkg::LIN_COEF[i];
        else w[i] = longint'(grs_pkg::LIN_COEF[i]) * counts[grs_pkg::LIN_SP[i]];
      end
      w[2] = bite_rate(1475, 32768, counts[0], counts[5]);
      w[5] = bite_rate(2458, 9830, counts[1], counts[4]);
      total = 0;
      foreach (w[i]) total += w[i];
      tau = (wait_neglog(dw) << 16) / total;
      target = ((total * (dp >> 16)) + ((total * (dp & 16'hFFFF)) >> 16)) >> 16;
      r = 0;
      cum = w[0];
      while (cum < target && r < grs_pkg::NUM_REACTIONS - 1) begin
        r++;
        cum += w[r];
      end
      rxn = 4'(r);
      if (grs_pkg::LOSE_SP[r] != grs_pkg::SP_NONE) begin
        if (counts[grs_pkg::LOSE_SP[r]] == 0) sat = 1;
        else counts[grs_pkg::LOSE_SP[r]]--;
      end
      if (grs_pkg::GAIN_SP[r] != grs_pkg::SP_NONE) begin
        if (counts[grs_pkg::GAIN_SP[r]] >= CNT_TOP) sat = 1;
        else counts[grs_pkg::GAIN_SP[r]]++;
      end
      nclk = clock_q16 + tau;
      if (nclk > 64'hFFFF_FFFF) begin
        nclk = 64'hFFFF_FFFF;
        sat = 1;
      end
      clock_q16 = nclk;
      run_finished = (clock_q16 >= stop_q16);
    end
    return pack_result(rxn, sat);
  endfunction

  // result side: random stall, compare against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        step_result_t got, want;
        got = '{out_reaction_fired, out_elapsed_time, out_count_s_h, out_count_s_m,
                out_count_e_h, out_count_e_m, out_count_i_h, out_count_i_m,
                out_count_r_h, out_run_done, out_saturated};
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word %h", $time, got);
        end else begin
          want = expected_q.pop_front();
          words_checked++;
          if (got.rxn != grs_pkg::RXN_NONE) steps_fired++;
          if (got.rxn != want.rxn) begin errors++;
            $display("%0t: reaction exp %0d got %0d", $time, want.rxn, got.rxn); end
          if (got.clock_q16 != want.clock_q16) begin errors++;
            $display("%0t: time exp %h got %h", $time, want.clock_q16, got.clock_q16); end
          if (got.sh != want.sh) begin errors++;
            $display("%0t: S_h exp %0d got %0d", $time, want.sh, got.sh); end
          if (got.sm != want.sm) begin errors++;
            $display("%0t: S_m exp %0d got %0d", $time, want.sm, got.sm); end
          if (got.eh != want.eh) begin errors++;
            $display("%0t: E_h exp %0d got %0d", $time, want.eh, got.eh); end
          if (got.em != want.em) begin errors++;
            $display("%0t: E_m exp %0d got %0d", $time, want.em, got.em); end
          if (got.ih != want.ih) begin errors++;
            $display("%0t: I_h exp %0d got %0d", $time, want.ih, got.ih); end
          if (got.im != want.im) begin errors++;
            $display("%0t: I_m exp %0d got %0d", $time, want.im, got.im); end
          if (got.rh != want.rh) begin errors++;
            $display("%0t: R_h exp %0d got %0d", $time, want.rh, got.rh); end
          if (got.done != want.done) begin errors++;
            $display("%0t: done exp %0d got %0d", $time, want.done, got.done); end
          if (got.sat != want.sat) begin errors++;
            $display("%0t: sat exp %0d got %0d", $time, want.sat, got.sat); end
        end
      end
      out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 36);
    end
  end

  // one register write, then cfg_we drops before the next
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == grs_pkg::CFG_STOP_TIME) stop_q16 = val;
    else init_cnt[idx - 1] = val[15:0];
    @(posedge clk);
  endtask

  // drop valid, wait for every result, then let the core settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // one word: random gap, hold until accepted; known rows override the predictor.
  // valid stays up on return; the next word or a drain takes it down.
  task automatic send_word(logic op, logic [31:0] dw, logic [31:0] dp,
                           bit known = 0, step_result_t want = '0);
    step_result_t pred;
    while (!no_idle && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_draw_wait <= dw;
    in_draw_pick <= dp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = advance_epidemic(op, dw, dp);
    expected_q.push_back(known ? want : pred);
    words_sent++;
  endtask

  function automatic logic [31:0] rand_draw();
    case ($urandom_range(4))
      0: return $urandom_range(1, 1023);             // tiny draws, deep log
      1: return 32'hFFFF_FFFF - $urandom_range(255);
      default: return $urandom() | 32'h1;
    endcase
  endfunction

  stim_row_t directed [$];
  step_result_t row_want;

  initial begin
    in_valid = 0; in_op = 0; in_draw_wait = 0; in_draw_pick = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    errors = 0; words_sent = 0; words_checked = 0; steps_fired = 0;
    no_idle = 0;
    rst_n = 0;
    stop_q16 = grs_pkg::STOP_RESET;
    foreach (init_cnt[i]) begin
      init_cnt[i] = grs_pkg::INIT_RESET[i];
      counts[i]   = grs_pkg::INIT_RESET[i];
    end
    clock_q16 = 0;
    run_finished = 0;
    for (int k = 0; k < (1 << LOG_BITS); k++) ln_table[k] = log_rom_entry(k);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; start after reset reads the default counts
    row_want = '{grs_pkg::RXN_NONE, 32'd0, 16'd900, 16'd900, 16'd30, 16'd330, 16'd50,
                 16'd270, 16'd20, 1'b0, 1'b0};
    directed.push_back('{grs_pkg::OP_START_RUN, 32'h0, 32'h0, 1, row_want});
    directed.push_back('{grs_pkg::OP_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0});
    directed.push_back('{grs_pkg::OP_STEP, 32'h0, 32'h0, 0, '0});   // zero wait draw
    directed.push_back('{grs_pkg::OP_STEP, 32'h1, 32'h1, 0, '0});
    directed.push_back('{grs_pkg::OP_STEP, 32'h8000_0000, 32'h8000_0000, 0, '0});
    directed.push_back('{grs_pkg::OP_STEP, 32'h0000_0400, 32'h5555_5555, 0, '0});
    directed.push_back('{grs_pkg::OP_STEP, 32'h0000_03FF, 32'hAAAA_AAAA, 0, '0});
    directed.push_back('{grs_pkg::OP_STEP, 32'h7FFF_FFFF, 32'h0000_0000, 0, '0});
    directed.push_back('{grs_pkg::OP_START_RUN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0});
    foreach (directed[i])
      send_word(directed[i].op, directed[i].dw, directed[i].dp,
                directed[i].known, directed[i].want);
    drain_results();

    // stop time zero: start finishes at once, steps after it are skipped
    cfg_write(grs_pkg::CFG_STOP_TIME, 32'd0);
    row_want = '{grs_pkg::RXN_NONE, 32'd0, 16'd900, 16'd900, 16'd30, 16'd330, 16'd50,
                 16'd270, 16'd20, 1'b1, 1'b0};
    send_word(grs_pkg::OP_START_RUN, 0, 0, 1, row_want);
    send_word(grs_pkg::OP_STEP, 32'h1234_5678, 32'h9ABC_DEF0, 1, row_want);
    drain_results();

    // extreme counts: all zero, then all at the top
    cfg_write(grs_pkg::CFG_STOP_TIME, 32'hFFFF_FFFF);
    for (int i = 1; i <= grs_pkg::NUM_SPECIES; i++) cfg_write(3'(i), 32'd0);
    send_word(grs_pkg::OP_START_RUN, 0, 0);
    for (int i = 0; i < 6; i++) send_word(grs_pkg::OP_STEP, rand_draw(), rand_draw());
    send_word(grs_pkg::OP_STEP, 32'h1, 32'h1);   // longest wait, first reaction
    send_word(grs_pkg::OP_STEP, 32'h1, 32'h1);
    drain_results();
    for (int i = 1; i <= grs_pkg::NUM_SPECIES; i++)
      cfg_write(3'(i), 32'hFFFF_0000 | CNT_TOP);
    send_word(grs_pkg::OP_START_RUN, 0, 0);
    for (int i = 0; i < 6; i++) send_word(grs_pkg::OP_STEP, rand_draw(), rand_draw());
    drain_results();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(grs_pkg::CFG_STOP_TIME,
                ph == 5 ? 32'hFFFF_FFFF : $urandom_range(1, 32'h0020_0000));
      for (int i = 1; i <= grs_pkg::NUM_SPECIES; i++)
        cfg_write(3'(i), $urandom_range(5) == 0 ? $urandom() : $urandom_range(0, 2000));
      no_idle = (ph == 2);
      for (int n = 0; n < NUM_RANDOM / 6; n++) begin
        if (n == 0 || $urandom_range(39) == 0)
          send_word(grs_pkg::OP_START_RUN, $urandom(), $urandom());
        else send_word(grs_pkg::OP_STEP, rand_draw(), $urandom());
        if (n == 40) begin
          // hold off until the core has emptied
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
      end
      no_idle = 0;
      drain_results();
    end

    $display("%0d words sent, %0d results checked, %0d reactions fired",
             words_sent, words_checked, steps_fired);
    $display("covered start/step, zero and top counts, stop time zero and skips");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
